@@ sv/point_in_polygon_test_core_macros.svh @@
// ----------------------------------------------------------------------------
// Point-in-polygon test assertion macros
// Shared concurrent assertion forms for the point-in-polygon test core.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_MACROS_SVH
`define POINT_IN_POLYGON_TEST_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip assertion failed");

`endif

@@ sv/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants, item kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_WIDTH  = 32;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOX   = 2'd2;

    // One million in Q24.8.
    localparam int BOX_FAR = 256000000;

    typedef struct packed {
        logic start_q;
        logic start_box;
        logic wr_en;
        logic rd_en;
        logic rd_eval;
        logic rd_box;
        logic load_res;
    } pip_cmd_t;

    typedef struct packed {
        logic busy;
        logic inbox;
    } pip_status_t;

endpackage

`default_nettype wire

@@ sv/pip_ram.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/pip_dp.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon datapath
// Vertex memory, vertex window, bounding box and the three-stage edge test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_in_polygon_test_core_macros.svh"

module pip_dp import pip_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    parameter int IDX_W        = $clog2(DEF_MAX_VERTICES)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pip_cmd_t                      cmd,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [IDX_W-1:0]              rd_addr,
    input  wire logic signed [COORD_WIDTH-1:0] coord_x,
    input  wire logic signed [COORD_WIDTH-1:0] coord_y,
    output pip_status_t                        status,
    output logic                               inside_res
);

    localparam int CW = COORD_WIDTH;
    localparam int BW = (CW > 30) ? CW : 30;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [BW-1:0] FAR_POS = BW'(BOX_FAR);
    localparam logic signed [BW-1:0] FAR_NEG = -BW'(BOX_FAR);

    logic [2*CW-1:0] rdata;
    logic signed [CW-1:0] rd_x, rd_y;

    logic rdv_reg, rde_reg, rdb_reg;
    logic win_vld_reg, e_vld_reg, m_vld_reg;
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] prev_y_reg, cur_x_reg, cur_y_reg, nxt_x_reg, nxt_y_reg;
    logic signed [BW-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic signed [BW-1:0] px_ext, py_ext, rx_ext, ry_ext;
    logic inbox_reg, parity_reg, hit_reg;

    logic lev, hit, vcnt, skip;
    logic signed [DW-1:0] dy_raw, b_raw, a_val, dx_val;
    logic e_hit_reg, e_vcnt_reg, e_edge_reg;
    logic signed [DW-1:0] a_reg, b_reg, dx_reg, dy_reg;
    logic m_hit_reg, m_vcnt_reg, m_edge_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;

    pip_ram #(
        .WIDTH(2 * CW),
        .DEPTH(MAX_VERTICES)
    ) u_ram (
        .clk  (clk),
        .we   (cmd.wr_en),
        .waddr(wr_addr),
        .wdata({coord_x, coord_y}),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    assign rd_x   = rdata[2*CW-1:CW];
    assign rd_y   = rdata[CW-1:0];
    assign px_ext = BW'(coord_x);
    assign py_ext = BW'(coord_y);
    assign rx_ext = BW'(rd_x);
    assign ry_ext = BW'(rd_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg     <= 1'b0;
            rde_reg     <= 1'b0;
            rdb_reg     <= 1'b0;
            win_vld_reg <= 1'b0;
            e_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            min_x_reg   <= FAR_POS;
            min_y_reg   <= FAR_POS;
            max_x_reg   <= FAR_NEG;
            max_y_reg   <= FAR_NEG;
            inbox_reg   <= 1'b0;
            parity_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            rdv_reg     <= cmd.rd_en;
            rde_reg     <= cmd.rd_eval;
            rdb_reg     <= cmd.rd_box;
            win_vld_reg <= rdv_reg && rde_reg && !rdb_reg;
            e_vld_reg   <= win_vld_reg;
            m_vld_reg   <= e_vld_reg;
            if (cmd.start_box)
            begin
                min_x_reg <= FAR_POS;
                min_y_reg <= FAR_POS;
                max_x_reg <= FAR_NEG;
                max_y_reg <= FAR_NEG;
            end
            else if (rdv_reg && rdb_reg)
            begin
                if (rx_ext < min_x_reg) min_x_reg <= rx_ext;
                if (rx_ext > max_x_reg) max_x_reg <= rx_ext;
                if (ry_ext < min_y_reg) min_y_reg <= ry_ext;
                if (ry_ext > max_y_reg) max_y_reg <= ry_ext;
            end
            if (cmd.start_q)
            begin
                inbox_reg  <= !(px_ext < min_x_reg || px_ext > max_x_reg ||
                                py_ext < min_y_reg || py_ext > max_y_reg);
                parity_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else if (m_vld_reg)
            begin
                if (m_hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (m_vcnt_reg || (m_edge_reg && (p1_reg <= p2_reg)))
                begin
                    parity_reg <= !parity_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_q)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rdv_reg && !rdb_reg)
        begin
            prev_y_reg <= cur_y_reg;
            cur_x_reg  <= nxt_x_reg;
            cur_y_reg  <= nxt_y_reg;
            nxt_x_reg  <= rd_x;
            nxt_y_reg  <= rd_y;
        end
        if (cmd.load_res)
        begin
            inside_res <= inbox_reg && (hit_reg || parity_reg);
        end
    end

    always_comb
    begin
        lev  = (cur_y_reg == py_reg) && (cur_x_reg <= px_reg);
        hit  = lev && (cur_x_reg == px_reg);
        vcnt = lev && !hit &&
               !((prev_y_reg > py_reg && nxt_y_reg > py_reg) ||
                 (prev_y_reg < py_reg && nxt_y_reg < py_reg));
        skip = (cur_y_reg > py_reg && nxt_y_reg >= py_reg) ||
               (cur_y_reg < py_reg && nxt_y_reg <= py_reg) ||
               (cur_x_reg > px_reg && nxt_x_reg > px_reg) ||
               (cur_y_reg == nxt_y_reg);
        dy_raw = DW'(nxt_y_reg) - DW'(cur_y_reg);
        b_raw  = DW'(py_reg) - DW'(cur_y_reg);
        a_val  = DW'(px_reg) - DW'(cur_x_reg);
        dx_val = DW'(nxt_x_reg) - DW'(cur_x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (win_vld_reg)
        begin
            e_hit_reg  <= hit;
            e_vcnt_reg <= vcnt;
            e_edge_reg <= !lev && !skip;
            a_reg      <= a_val;
            dx_reg     <= dx_val;
            dy_reg     <= dy_raw[DW-1] ? -dy_raw : dy_raw;
            b_reg      <= dy_raw[DW-1] ? -b_raw : b_raw;
        end
        if (e_vld_reg)
        begin
            m_hit_reg  <= e_hit_reg;
            m_vcnt_reg <= e_vcnt_reg;
            m_edge_reg <= e_edge_reg;
            p1_reg     <= PW'(b_reg) * PW'(dx_reg);
            p2_reg     <= PW'(a_reg) * PW'(dy_reg);
        end
    end

    assign status.busy  = rdv_reg || win_vld_reg || e_vld_reg || m_vld_reg;
    assign status.inbox = inbox_reg;

    `PIP_ASSERT_NEXT(a_win_follows_read, clk, rst_n, rdv_reg && rde_reg && !rdb_reg, win_vld_reg)
    `PIP_ASSERT_NEXT(a_pipe_moves, clk, rst_n, e_vld_reg, m_vld_reg)
    `PIP_ASSERT_SAME(a_no_box_during_query, clk, rst_n, win_vld_reg, !(rdv_reg && rdb_reg))

endmodule

`default_nettype wire

@@ sv/pip_ctrl.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon controller
// Accepts transactions, walks the vertex memory and hands back the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_in_polygon_test_core_macros.svh"

module pip_ctrl import pip_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int IDX_W        = $clog2(DEF_MAX_VERTICES),
    parameter int CNT_W        = $clog2(DEF_MAX_VERTICES + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [IDX_W-1:0]  vertex_index,
    input  wire logic              cfg_we,
    input  wire logic [CNT_W-1:0]  cfg_wdata,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire pip_status_t       status,
    output pip_cmd_t               cmd,
    output logic [IDX_W-1:0]       rd_addr
);

    localparam int K_W = $clog2(MAX_VERTICES + 3);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QRY   = 3'd1;
    localparam logic [2:0] ST_BOX   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;

    logic [2:0]       state_reg, state_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             qmode_reg, qmode_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] used;
    logic [K_W-1:0]   nk, addr_full;
    logic             acc;

    assign used     = (vcount_reg > MAX_CNT) ? MAX_CNT : vcount_reg;
    assign nk       = K_W'(used);
    assign in_stall = (state_reg != ST_IDLE);
    assign acc      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign rd_addr  = addr_full[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        qmode_next     = qmode_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        addr_full      = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    k_next = '0;
                    case (kind)
                        KIND_WRITE:
                        begin
                            cmd.wr_en = (K_W'(vertex_index) < K_W'(MAX_VERTICES));
                        end
                        KIND_QUERY:
                        begin
                            cmd.start_q = 1'b1;
                            qmode_next  = 1'b1;
                            state_next  = (used == '0) ? ST_DRAIN : ST_QRY;
                        end
                        KIND_BOX:
                        begin
                            cmd.start_box = 1'b1;
                            qmode_next    = 1'b0;
                            state_next    = (used == '0) ? ST_IDLE : ST_BOX;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QRY:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_eval = (k_reg >= K_W'(2));
                if (k_reg == '0)
                begin
                    addr_full = nk - K_W'(1);
                end
                else if (k_reg == nk + K_W'(1))
                begin
                    addr_full = '0;
                end
                else
                begin
                    addr_full = k_reg - K_W'(1);
                end
                k_next = k_reg + K_W'(1);
                if (k_reg == nk + K_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_BOX:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_box = 1'b1;
                k_next     = k_reg + K_W'(1);
                if (k_reg == nk - K_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    if (!qmode_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!out_valid_reg || !out_stall)
                    begin
                        cmd.load_res   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            qmode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            vcount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            qmode_reg     <= qmode_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    `PIP_ASSERT_SAME(a_read_only_in_walk, clk, rst_n, cmd.rd_en, state_reg == ST_QRY || state_reg == ST_BOX)
    `PIP_ASSERT_SAME(a_load_needs_free_out, clk, rst_n, cmd.load_res, !out_valid_reg || !out_stall)
    `PIP_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_res, out_valid_reg)
    `PIP_ASSERT_NEXT(a_held_result_stays, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)

endmodule

`default_nettype wire

@@ sv/point_in_polygon_test_core.sv @@
// ----------------------------------------------------------------------------
// Point-in-polygon test core
// Ray-crossing parity test over a stored polygon in signed Q24.8 coordinates.
// ----------------------------------------------------------------------------
// A vertex write transaction goes to the vertex memory as it is accepted. A
// bounding-box transaction reads the n vertices in use from the vertex memory,
// one per cycle. A query transaction reads n + 2 vertices through the single
// memory read port, one per cycle, then drains a three-stage edge pipeline. The
// memory needs no clearing pass after reset. A finished result waits in the
// output register while the next transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_core import pip_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [KIND_W-1:0]                   kind,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]     vertex_index,
    input  wire logic signed [COORD_WIDTH-1:0]       coord_x,
    input  wire logic signed [COORD_WIDTH-1:0]       coord_y,
    input  wire logic                                cfg_we,
    input  wire logic [$clog2(MAX_VERTICES + 1)-1:0] cfg_wdata,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     inside_res
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    pip_cmd_t         cmd;
    pip_status_t      status;
    logic [IDX_W-1:0] rd_addr;

    pip_ctrl #(
        .MAX_VERTICES(MAX_VERTICES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .vertex_index(vertex_index),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (vertex_index),
        .rd_addr   (rd_addr),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .status    (status),
        .inside_res(inside_res)
    );

endmodule

`default_nettype wire
